// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker module of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GCKV_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("gckv assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GCKV_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("gckv assertion failed");

`endif

// ===== rtl/gckv_pkg.sv =====
// Types, character constants and the key classifier of the key/value parser.
`default_nettype none

package gckv_pkg;

    // Command codes of an input word; code 3 behaves as CMD_END.
    localparam logic [1:0] CMD_BYTE = 2'd0;
    localparam logic [1:0] CMD_LAST = 2'd1;
    localparam logic [1:0] CMD_END  = 2'd2;

    // Section syntax characters.
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Recognized keys.
    localparam logic [7:0] KEY_A  = 8'h61;
    localparam logic [7:0] KEY_D  = 8'h64;
    localparam logic [7:0] KEY_T  = 8'h74;
    localparam logic [7:0] KEY_O  = 8'h6F;
    localparam logic [7:0] KEY_F  = 8'h66;
    localparam logic [7:0] KEY_S  = 8'h73;
    localparam logic [7:0] KEY_V  = 8'h76;
    localparam logic [7:0] KEY_C  = 8'h63;
    localparam logic [7:0] KEY_R  = 8'h72;
    localparam logic [7:0] KEY_I  = 8'h69;
    localparam logic [7:0] KEY_Q  = 8'h71;
    localparam logic [7:0] KEY_M  = 8'h6D;
    localparam logic [7:0] KEY_UC_S = 8'h53;

    // How the value of a key is reported.
    typedef enum logic [1:0] {
        KIND_OTHER,
        KIND_BYTE,
        KIND_NUM,
        KIND_BOOL
    } key_kind_t;

    // Parser position within a pair.
    typedef enum logic [1:0] {
        PH_KEY,
        PH_EQ,
        PH_VALUE
    } phase_t;

    // Classified input word, as it travels from the front end to the back end.
    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
        logic       is_eq;
        logic       is_comma;
        logic       is_digit;
        logic [3:0] digit;
        key_kind_t  kind;
    } cls_word_t;

    // Map a key character to the way its value is reported.
    function automatic key_kind_t key_kind(input logic [7:0] b);
        key_kind_t k;
        unique case (b)
            KEY_A, KEY_D, KEY_T, KEY_O:                      k = KIND_BYTE;
            KEY_F, KEY_S, KEY_V, KEY_C, KEY_R, KEY_I, KEY_Q,
            KEY_UC_S:                                        k = KIND_NUM;
            KEY_M:                                           k = KIND_BOOL;
            default:                                         k = KIND_OTHER;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/gckv_in_if.sv =====
// Input channel of the key/value parser: one section byte and its command.
`default_nettype none

interface gckv_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/gckv_out_if.sv =====
// Output channel of the key/value parser: a reported pair and/or the section result.
`default_nettype none

interface gckv_out_if;
    logic        valid;
    logic        ready;
    logic        pair_valid;
    logic [7:0]  key_code;
    logic [31:0] pair_value;
    logic        done_res;
    logic        status;

    modport source (output valid, output pair_valid, output key_code, output pair_value,
                    output done_res, output status, input ready);
    modport sink   (input valid, input pair_valid, input key_code, input pair_value,
                    input done_res, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/gckv_front.sv =====
// Front end: accepts input words and classifies each byte before queueing it.
`default_nettype none

module gckv_front
    import gckv_pkg::*;
(
    gckv_in_if.sink   in_ch,
    input  wire logic q_full,
    output logic      push,
    output cls_word_t push_word
);

    // A word is taken whenever the queue has room.
    assign in_ch.ready = !q_full;
    assign push        = in_ch.valid && !q_full;

    // Byte classification.
    always_comb
    begin
        push_word.command   = in_ch.command;
        push_word.data_byte = in_ch.data_byte;
        push_word.is_eq     = (in_ch.data_byte == CH_EQ);
        push_word.is_comma  = (in_ch.data_byte == CH_COMMA);
        push_word.is_digit  = (in_ch.data_byte >= CH_ZERO) && (in_ch.data_byte <= CH_NINE);
        push_word.digit     = 4'(in_ch.data_byte - CH_ZERO);
        push_word.kind      = key_kind(in_ch.data_byte);
    end

endmodule

`default_nettype wire

// ===== rtl/gckv_queue.sv =====
// Short queue of classified words between the front end and the back end.
`default_nettype none

module gckv_queue
    import gckv_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire cls_word_t push_word,
    input  wire logic      pop,
    output logic           full,
    output logic           not_empty,
    output cls_word_t      pop_word
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cls_word_t              mem [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_word  = mem[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/gckv_back.sv =====
// Back end: runs the pair parser on queued words and drives the output register.
`default_nettype none

module gckv_back
    import gckv_pkg::*;
#(
    parameter int MAX_VALUE_CHARS = 31
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      q_not_empty,
    input  wire cls_word_t q_word,
    output logic           pop,
    gckv_out_if.source     out_ch
);

    localparam int VLEN_W = $clog2(MAX_VALUE_CHARS + 1);

    // Parser state.
    phase_t             phase_reg, phase_next, phase_mid;
    logic [7:0]         held_key_reg, held_key_next;
    key_kind_t          kind_reg, kind_next;
    logic [31:0]        acc_reg, acc_next, acc_mid;
    logic               ovf_reg, ovf_next, ovf_mid;
    logic [VLEN_W-1:0]  vlen_reg, vlen_next, vlen_mid;
    logic [7:0]         first_reg, first_next, first_mid;
    logic               bad_reg, bad_next, bad_mid;
    logic               err_reg, err_next, err_mid, err_out;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    logic               pv_reg, pv_next;
    logic [7:0]         key_reg, key_next;
    logic [31:0]        val_reg, val_next;
    logic               done_reg, done_next;
    logic               stat_reg, stat_next;

    // Word events.
    logic               advance;
    logic               byte_act, ends;
    logic               key_load, eq_bad, val_open, take, comma_fin;
    logic               do_finish, fin_empty, fin_numbad, fin_err, fin_valid;
    logic               pair_out, emit;
    logic [35:0]        times_ten;
    logic [31:0]        fin_value;

    // The output register frees up when it is empty or being taken.
    assign advance = !out_valid_reg || out_ch.ready;
    assign pop     = q_not_empty && advance;

    // Decode what the current word does at the current position.
    always_comb
    begin
        byte_act  = ((q_word.command == CMD_BYTE) || (q_word.command == CMD_LAST)) && !err_reg;
        ends      = (q_word.command != CMD_BYTE);
        key_load  = byte_act && (phase_reg == PH_KEY);
        eq_bad    = byte_act && (phase_reg == PH_EQ) && !q_word.is_eq;
        val_open  = byte_act && (phase_reg == PH_EQ) && q_word.is_eq;
        take      = byte_act && (phase_reg == PH_VALUE) && !q_word.is_comma;
        comma_fin = byte_act && (phase_reg == PH_VALUE) && q_word.is_comma;
    end

    // Next-state logic of the pair position.
    always_comb
    begin
        phase_mid = phase_reg;
        if (key_load)
        begin
            phase_mid = PH_EQ;
        end
        else if (val_open)
        begin
            phase_mid = PH_VALUE;
        end
        else if (comma_fin)
        begin
            phase_mid = PH_KEY;
        end
        phase_next = ends ? PH_KEY : phase_mid;
    end

    // Value accumulation, pair completion and result forming.
    always_comb
    begin
        acc_mid   = acc_reg;
        ovf_mid   = ovf_reg;
        vlen_mid  = vlen_reg;
        first_mid = first_reg;
        bad_mid   = bad_reg;
        times_ten = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + 36'(q_word.digit);

        // A new value starts from cleared counters.
        if (val_open)
        begin
            acc_mid   = '0;
            ovf_mid   = 1'b0;
            vlen_mid  = '0;
            first_mid = '0;
            bad_mid   = 1'b0;
        end

        // One value byte: length, first byte and the decimal accumulator.
        if (take)
        begin
            if (vlen_reg == '0)
            begin
                first_mid = q_word.data_byte;
            end
            if (vlen_reg >= VLEN_W'(MAX_VALUE_CHARS))
            begin
                bad_mid = 1'b1;
            end
            else
            begin
                vlen_mid = vlen_reg + 1'b1;
            end
            if (!q_word.is_digit)
            begin
                bad_mid = 1'b1;
            end
            else if (!ovf_reg)
            begin
                if (|times_ten[35:32])
                begin
                    ovf_mid = 1'b1;
                end
                else
                begin
                    acc_mid = times_ten[31:0];
                end
            end
        end

        err_mid = err_reg || eq_bad;

        // Pair completion on a comma or at the end of the section.
        do_finish  = comma_fin || (ends && !err_mid && (phase_mid == PH_VALUE));
        fin_empty  = (vlen_mid == '0);
        fin_numbad = ((kind_reg == KIND_NUM) || (kind_reg == KIND_BOOL)) && (bad_mid || ovf_mid);
        fin_err    = fin_empty || fin_numbad;
        fin_valid  = !fin_empty && !fin_numbad && (kind_reg != KIND_OTHER);
        unique case (kind_reg)
            KIND_BYTE: fin_value = {24'b0, first_mid};
            KIND_NUM:  fin_value = acc_mid;
            KIND_BOOL: fin_value = {31'b0, |acc_mid};
            default:   fin_value = '0;
        endcase

        err_out  = err_mid || (do_finish && fin_err)
                   || (ends && !err_mid && (phase_mid == PH_EQ));
        pair_out = do_finish && fin_valid && !err_out;
        emit     = ends || pair_out;

        pv_next   = pair_out;
        key_next  = pair_out ? held_key_reg : 8'h00;
        val_next  = pair_out ? fin_value : 32'h0;
        done_next = ends;
        stat_next = ends && err_out;

        // The end of a section returns every parser state register to its reset value.
        if (ends)
        begin
            held_key_next = '0;
            kind_next     = KIND_OTHER;
            acc_next      = '0;
            ovf_next      = 1'b0;
            vlen_next     = '0;
            first_next    = '0;
            bad_next      = 1'b0;
            err_next      = 1'b0;
        end
        else
        begin
            held_key_next = key_load ? q_word.data_byte : held_key_reg;
            kind_next     = key_load ? q_word.kind : kind_reg;
            acc_next      = acc_mid;
            ovf_next      = ovf_mid;
            vlen_next     = vlen_mid;
            first_next    = first_mid;
            bad_next      = bad_mid;
            err_next      = err_out;
        end

        out_valid_next = advance ? (pop && emit) : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_KEY;
            held_key_reg  <= '0;
            kind_reg      <= KIND_OTHER;
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            vlen_reg      <= '0;
            first_reg     <= '0;
            bad_reg       <= 1'b0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                phase_reg    <= phase_next;
                held_key_reg <= held_key_next;
                kind_reg     <= kind_next;
                acc_reg      <= acc_next;
                ovf_reg      <= ovf_next;
                vlen_reg     <= vlen_next;
                first_reg    <= first_next;
                bad_reg      <= bad_next;
                err_reg      <= err_next;
            end
        end
    end

    // Result payload is loaded when a word that produces a result is popped.
    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            pv_reg   <= pv_next;
            key_reg  <= key_next;
            val_reg  <= val_next;
            done_reg <= done_next;
            stat_reg <= stat_next;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.pair_valid = pv_reg;
    assign out_ch.key_code   = key_reg;
    assign out_ch.pair_value = val_reg;
    assign out_ch.done_res   = done_reg;
    assign out_ch.status     = stat_reg;

endmodule

`default_nettype wire

// ===== rtl/graphics_control_key_value_parser.sv =====
// Top level of the control-section key/value parser.
//
//   channel   direction   word contents
//   in_ch     sink        command, data_byte
//   out_ch    source      pair_valid, key_code, pair_value, done_res, status
//
// One word per cycle sustained in both directions when nothing stalls; a word
// is queued and, once popped, loads any result into the output register.
// The back end updates its accumulator (times ten plus digit) per value digit.
// Reset is asynchronous and clears the queue, the parser state and the output.
// A stalled output holds its word; up to QUEUE_DEPTH input words are buffered
// before in_ch.ready falls.
`default_nettype none

module graphics_control_key_value_parser
    import gckv_pkg::*;
#(
    parameter int MAX_VALUE_CHARS = 31,
    parameter int QUEUE_DEPTH     = 4
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    gckv_in_if.sink     in_ch,
    gckv_out_if.source  out_ch
);

    logic      q_full;
    logic      q_not_empty;
    logic      push;
    logic      pop;
    cls_word_t push_word;
    cls_word_t pop_word;

    gckv_front u_front (
        .in_ch     (in_ch),
        .q_full    (q_full),
        .push      (push),
        .push_word (push_word)
    );

    gckv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .pop_word  (pop_word)
    );

    gckv_back #(
        .MAX_VALUE_CHARS (MAX_VALUE_CHARS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_word      (pop_word),
        .pop         (pop),
        .out_ch      (out_ch)
    );

endmodule

`default_nettype wire

// ===== rtl/gckv_checker.sv =====
// Port-level checks of the key/value parser and their binding to the top level.
`default_nettype none
`include "assert_macros.svh"

module gckv_checker
    import gckv_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        pair_valid,
    input wire logic [7:0]  key_code,
    input wire logic [31:0] pair_value,
    input wire logic        done_res,
    input wire logic        status
);

    logic        known_key;
    logic        stall;
    logic [42:0] payload;
    logic        close_only;
    logic        mode_word;

    assign known_key = (key_code == KEY_A) || (key_code == KEY_D) || (key_code == KEY_T)
                       || (key_code == KEY_O) || (key_code == KEY_F) || (key_code == KEY_S)
                       || (key_code == KEY_V) || (key_code == KEY_C) || (key_code == KEY_R)
                       || (key_code == KEY_I) || (key_code == KEY_Q) || (key_code == KEY_M)
                       || (key_code == KEY_UC_S);
    assign stall      = out_valid && !out_ready;
    assign payload    = {pair_valid, key_code, pair_value, done_res, status};
    assign close_only = done_res && (key_code == 8'h00) && (pair_value == 32'h0);
    assign mode_word  = out_valid && pair_valid && (key_code == KEY_M);

    // A stalled word stays offered and unchanged.
    `GCKV_ASSERT_NEXT(a_out_hold, clk, rst_n, stall, out_valid && $stable(payload))

    // An error is only reported on the word that closes a section.
    `GCKV_ASSERT_SAME(a_status_done, clk, rst_n, out_valid && status, done_res)

    // A word that carries neither a pair nor the closing result is never sent.
    `GCKV_ASSERT_SAME(a_no_empty_word, clk, rst_n, out_valid && !pair_valid, close_only)

    // Only recognized keys are reported, and never together with an error.
    `GCKV_ASSERT_SAME(a_known_key, clk, rst_n, out_valid && pair_valid, known_key && !status)

    // The mode key reports zero or one.
    `GCKV_ASSERT_SAME(a_mode_bool, clk, rst_n, mode_word, pair_value[31:1] == 31'h0)

endmodule

bind graphics_control_key_value_parser gckv_checker u_gckv_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .pair_valid (out_ch.pair_valid),
    .key_code   (out_ch.key_code),
    .pair_value (out_ch.pair_value),
    .done_res   (out_ch.done_res),
    .status     (out_ch.status)
);

`default_nettype wire
